// File: src/hsp_pkg.sv
// Shared types and constants for the histogram-shift pixel pass block.
`timescale 1ns / 1ps

package hsp_pkg;

  localparam int REC_DEPTH = 4096;
  localparam int REC_AW    = $clog2(REC_DEPTH);
  localparam int REC_IW    = REC_AW + 1;

  localparam int PIX_W     = 8;
  localparam int PAY_W     = 24;
  localparam int RBC_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [REC_IW-1:0] REC_DEPTH_I = REC_IW'(REC_DEPTH);

  typedef enum logic [1:0] {
    MODE_SHIFT   = 2'd0,
    MODE_EMBED   = 2'd1,
    MODE_EXTRACT = 2'd2,
    MODE_RESTORE = 2'd3
  } pass_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIN_USED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT  = 3'd5;

  typedef struct packed {
    pass_mode_t         pass_mode;
    logic [PIX_W-1:0]   peak_level;
    logic [PIX_W-1:0]   zero_level;
    logic               zero_bin_used;
    logic [PAY_W-1:0]   data_bit_limit;
    logic [RBC_W-1:0]   record_bit_count;
  } cfg_t;

  typedef struct packed {
    logic [REC_IW-1:0]  wr_idx;
    logic [REC_IW-1:0]  rd_idx;
    logic [PAY_W-1:0]   pay_cnt;
    logic               done;
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic               in_region;
    logic               data_bit;
    logic               frame_start;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic               data_bit_taken;
    logic               bit_out;
    logic               bit_out_valid;
    logic [RBC_W-1:0]   record_count;
    logic [PAY_W-1:0]   payload_count;
    logic               error;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [REC_AW-1:0]  addr;
    logic               data;
  } rec_wr_t;

endpackage

// File: src/hsp_record_ram.sv
// Single-bit record store with one write port and one registered read port.
`timescale 1ns / 1ps

module hsp_record_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [hsp_pkg::REC_AW-1:0] waddr,
  input  logic                      wdata,
  input  logic                      re,
  input  logic [hsp_pkg::REC_AW-1:0] raddr,
  output logic                      rdata
);

  logic mem [hsp_pkg::REC_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/hsp_pass_logic.sv
// Per-pixel pass logic: shift, embed, extract and restore for one pixel.
`timescale 1ns / 1ps

module hsp_pass_logic (
  input  hsp_pkg::cfg_t    cfg,
  input  hsp_pkg::state_t  st,
  input  hsp_pkg::item_t   item,
  input  logic             rd_bit,
  output hsp_pkg::state_t  st_next,
  output hsp_pkg::result_t res,
  output hsp_pkg::rec_wr_t wr
);

  logic [hsp_pkg::PIX_W-1:0]  px;
  logic [hsp_pkg::PIX_W-1:0]  peak;
  logic [hsp_pkg::PIX_W-1:0]  zero;
  logic [hsp_pkg::PIX_W:0]    zero_adj;
  logic                       up;
  logic                       down;
  logic                       wr_side;
  logic                       active;
  logic                       can_read;
  logic                       can_write;
  logic                       have;
  logic                       bitv;
  logic                       cur_hit;
  logic                       cur;
  logic                       taken;
  logic                       bout;
  logic                       bvalid;
  logic                       err;
  hsp_pkg::state_t            s0;
  hsp_pkg::state_t            sn;

  always_comb begin
    peak     = cfg.peak_level;
    zero     = cfg.zero_level;
    up       = peak > zero;
    down     = peak < zero;
    // neighbor of the zero bin on the peak side; 9 bits so it never wraps
    zero_adj = up ? ({1'b0, zero} + 9'd1) : ({1'b0, zero} - 9'd1);
    wr_side  = (cfg.pass_mode == hsp_pkg::MODE_SHIFT) ||
               (cfg.pass_mode == hsp_pkg::MODE_EXTRACT);

    // frame start clears the pass counters before the pixel is handled
    s0 = st;
    if (item.frame_start) begin
      s0.pay_cnt = '0;
      s0.done    = 1'b0;
      if (wr_side) begin
        s0.wr_idx = '0;
      end else begin
        s0.rd_idx = '0;
      end
    end

    sn        = s0;
    px        = item.pixel;
    taken     = 1'b0;
    bout      = 1'b0;
    bvalid    = 1'b0;
    err       = 1'b0;
    have      = 1'b0;
    bitv      = 1'b0;
    cur_hit   = 1'b0;
    cur       = 1'b0;
    wr.en     = 1'b0;
    wr.addr   = s0.wr_idx[hsp_pkg::REC_AW-1:0];
    wr.data   = 1'b0;
    active    = item.in_region && !s0.done;
    can_read  = (s0.rd_idx < s0.wr_idx) && (s0.rd_idx < hsp_pkg::REC_DEPTH_I);
    can_write = s0.wr_idx < hsp_pkg::REC_DEPTH_I;

    if (active) begin
      case (cfg.pass_mode)
        hsp_pkg::MODE_SHIFT: begin
          if (up || down) begin
            if (cfg.zero_bin_used) begin
              if ({1'b0, px} == zero_adj || px == zero) begin
                if (can_write) begin
                  wr.en     = 1'b1;
                  wr.data   = (px == zero);
                  sn.wr_idx = s0.wr_idx + 1'b1;
                end else begin
                  err = 1'b1;
                end
              end
            end
            if (up && px > zero && px < peak) begin
              px = px - 1'b1;
            end else if (down && px < zero && px > peak) begin
              px = px + 1'b1;
            end
          end
        end
        hsp_pkg::MODE_EMBED: begin
          if (px == peak) begin
            if (can_read) begin
              bitv      = rd_bit;
              have      = 1'b1;
              sn.rd_idx = s0.rd_idx + 1'b1;
            end else if (s0.pay_cnt < cfg.data_bit_limit) begin
              bitv       = item.data_bit;
              have       = 1'b1;
              sn.pay_cnt = s0.pay_cnt + 1'b1;
              taken      = 1'b1;
            end else begin
              sn.done = 1'b1;
            end
            if (have && bitv) begin
              if (up) begin
                px = px - 1'b1;
              end else if (down) begin
                px = px + 1'b1;
              end
            end
          end
        end
        hsp_pkg::MODE_EXTRACT: begin
          if (px == peak) begin
            cur_hit = 1'b1;
          end else if (up && px == peak - 1'b1) begin
            cur_hit = 1'b1;
            cur     = 1'b1;
            px      = px + 1'b1;
          end else if (down && px == peak + 1'b1) begin
            cur_hit = 1'b1;
            cur     = 1'b1;
            px      = px - 1'b1;
          end
          if (cur_hit) begin
            if (s0.wr_idx < cfg.record_bit_count) begin
              if (can_write) begin
                wr.en     = 1'b1;
                wr.data   = cur;
                sn.wr_idx = s0.wr_idx + 1'b1;
              end else begin
                err = 1'b1;
              end
            end else if (s0.pay_cnt < cfg.data_bit_limit) begin
              bout       = cur;
              bvalid     = 1'b1;
              sn.pay_cnt = s0.pay_cnt + 1'b1;
            end else begin
              sn.done = 1'b1;
            end
          end
        end
        hsp_pkg::MODE_RESTORE: begin
          if (up || down) begin
            if (up && px >= zero && px < peak) begin
              px = px + 1'b1;
            end else if (down && px <= zero && px > peak) begin
              px = px - 1'b1;
            end
            if (cfg.record_bit_count != '0 && {1'b0, px} == zero_adj) begin
              if (can_read) begin
                sn.rd_idx = s0.rd_idx + 1'b1;
                if (rd_bit) begin
                  px = up ? px - 1'b1 : px + 1'b1;
                end
              end else begin
                err = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    st_next            = sn;
    res.pixel_out      = px;
    res.data_bit_taken = taken;
    res.bit_out        = bout;
    res.bit_out_valid  = bvalid;
    res.record_count   = wr_side ? hsp_pkg::RBC_W'(sn.wr_idx) : hsp_pkg::RBC_W'(sn.rd_idx);
    res.payload_count  = sn.pay_cnt;
    res.error          = err;
  end

endmodule

// File: src/histogram_shift_pixel_pass.sv
// An accepted beat is registered in stage 1, and its result beat in the output register.
// Throughput: one pixel per cycle unless the output stalls; the record store read for the
// next pixel is issued as it is accepted, from the index the current pixel leaves behind.
// Reset (rst, synchronous): registers return to their reset values, counters clear,
// both stages empty; the record store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module histogram_shift_pixel_pass (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: pixel[7:0], in_region[8], data_bit[9], zero pad[15:10]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,
  // s_tuser: frame_start[0]
  input  logic                          s_tuser,
  // m_tdata: pixel_out[7:0], data_bit_taken[8], bit_out[9], bit_out_valid[10],
  //          record_count[23:11], payload_count[47:24], error[48], zero pad[55:49]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [55:0]                   m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsp_pkg::CFG_DAT_W-1:0] cfg_data
);

  hsp_pkg::cfg_t    cfg;
  hsp_pkg::state_t  st;
  hsp_pkg::state_t  st_next;
  hsp_pkg::item_t   s1_item;
  hsp_pkg::result_t res_next;
  hsp_pkg::result_t out_res;
  hsp_pkg::rec_wr_t wr;
  logic             s1_valid;
  logic             s1_fire;
  logic             s_accept;
  logic             rd_bit;
  logic             rd_rewind;
  logic [hsp_pkg::REC_IW-1:0] rd_idx_next;
  logic [hsp_pkg::REC_AW-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hsp_pkg::CFG_PASS_MODE:     cfg.pass_mode <= hsp_pkg::pass_mode_t'(cfg_data[1:0]);
        hsp_pkg::CFG_PEAK_LEVEL:    cfg.peak_level <= cfg_data[7:0];
        hsp_pkg::CFG_ZERO_LEVEL:    cfg.zero_level <= cfg_data[7:0];
        hsp_pkg::CFG_ZERO_BIN_USED: cfg.zero_bin_used <= cfg_data[0];
        hsp_pkg::CFG_DATA_LIMIT:    cfg.data_bit_limit <= cfg_data[hsp_pkg::PAY_W-1:0];
        hsp_pkg::CFG_RECORD_COUNT:  cfg.record_bit_count <= cfg_data[hsp_pkg::RBC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage 1 moves when the output register is empty or being drained
  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        m_tvalid <= 1'b1;
        st       <= st_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_item.pixel       <= s_tdata[7:0];
      s1_item.in_region   <= s_tdata[8];
      s1_item.data_bit    <= s_tdata[9];
      s1_item.frame_start <= s_tuser;
    end
    if (s1_fire) begin
      out_res <= res_next;
    end
  end

  // prefetch the record bit at the index the incoming pixel will see
  assign rd_rewind   = s_tuser && ((cfg.pass_mode == hsp_pkg::MODE_EMBED) ||
                                   (cfg.pass_mode == hsp_pkg::MODE_RESTORE));
  assign rd_idx_next = s1_fire ? st_next.rd_idx : st.rd_idx;
  assign rd_addr     = rd_rewind ? '0 : rd_idx_next[hsp_pkg::REC_AW-1:0];

  hsp_record_ram u_ram (
    .clk   (clk),
    .we    (wr.en && s1_fire),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (s_accept),
    .raddr (rd_addr),
    .rdata (rd_bit)
  );

  hsp_pass_logic u_logic (
    .cfg     (cfg),
    .st      (st),
    .item    (s1_item),
    .rd_bit  (rd_bit),
    .st_next (st_next),
    .res     (res_next),
    .wr      (wr)
  );

  assign m_tdata = {7'd0,
                    out_res.error,
                    out_res.payload_count,
                    out_res.record_count,
                    out_res.bit_out_valid,
                    out_res.bit_out,
                    out_res.data_bit_taken,
                    out_res.pixel_out};

  a_wr_idx_bound: assert property (@(posedge clk) disable iff (rst)
    st.wr_idx <= hsp_pkg::REC_DEPTH_I)
    else $error("record write index past store depth");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output side is free");

  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid)
    else $error("stage 1 advanced but no result beat presented");

  a_err_not_taken: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.error) |-> (!out_res.data_bit_taken && !out_res.bit_out_valid))
    else $error("error beat also reports a payload bit");

endmodule
